>>> hw/rtl/u8s_pkg.sv
package u8s_pkg;

    typedef logic [7:0] byte_t;

    // replacement for broken or invalid bytes
    localparam byte_t REPL_BYTE = 8'h3F;

    // continuation pattern 10xxxxxx
    localparam byte_t CONT_MASK = 8'hC0;
    localparam byte_t CONT_PAT  = 8'h80;

    // lead patterns 110xxxxx, 1110xxxx, 11110xxx
    localparam byte_t LEAD2_MASK = 8'hE0;
    localparam byte_t LEAD2_PAT  = 8'hC0;
    localparam byte_t LEAD3_MASK = 8'hF0;
    localparam byte_t LEAD3_PAT  = 8'hE0;
    localparam byte_t LEAD4_MASK = 8'hF8;
    localparam byte_t LEAD4_PAT  = 8'hF0;

    localparam byte_t ASCII_TOP = 8'h80;

    // result slots per input byte
    localparam int MAX_OUT = 4;

endpackage

>>> hw/rtl/u8s_in_if.sv
interface u8s_in_if;
    import u8s_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> hw/rtl/u8s_out_if.sv
interface u8s_out_if;
    import u8s_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/utf8_byte_sanitizer.sv
// Each input byte is registered first; its results are then loaded into the result buffer.
// One input byte per cycle while each byte yields at most one result and out_ch.ready is
// high; a byte that yields k results (up to 4) holds off the next byte until its last result
// drains, the single output port draining the result buffer one byte per cycle while ready.
// Reset (rst_n low, asynchronous): all buffers empty, no sequence held, pass-through off.
module utf8_byte_sanitizer (
    input  logic      clk,
    input  logic      rst_n,
    u8s_in_if.sink    in_ch,
    u8s_out_if.source out_ch
);
    import u8s_pkg::*;

    // input register
    logic  in_vld_reg;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // sequence state
    byte_t      held_reg [3];
    logic [1:0] hc_reg;
    logic [1:0] nc_reg;
    logic       pt_reg;

    // result buffer
    byte_t      buf_reg [MAX_OUT];
    logic [2:0] remain_reg;
    logic [1:0] rd_reg;
    logic       buf_last_reg;

    logic in_xfer;
    logic out_xfer;
    logic move;

    // lead decode
    logic       lead_emit;
    byte_t      lead_byte;
    logic       lead_hold;
    logic       lead_zero;
    logic [1:0] lead_need;

    // step results
    logic [1:0] pre_n;
    logic       pre_repl;
    logic       tail_en;
    byte_t      tail_byte;
    logic [2:0] res_n;
    byte_t      slot [MAX_OUT];
    logic       is_cont;

    // state next values
    logic [1:0] hc_next;
    logic [1:0] nc_next;
    logic       pt_next;
    logic       hold_wr;
    logic [1:0] hold_idx;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_xfer = out_ch.valid && out_ch.ready;
    assign move     = in_vld_reg &&
                      ((remain_reg == 3'd0) || ((remain_reg == 3'd1) && out_ch.ready));
    assign in_ch.ready = !in_vld_reg || move;

    assign out_ch.valid    = (remain_reg != 3'd0);
    assign out_ch.out_byte = buf_reg[rd_reg];
    assign out_ch.out_last = buf_last_reg && (remain_reg == 3'd1);

    // lead byte handling
    always_comb
    begin
        lead_need = 2'd0;
        if ((in_byte_reg & LEAD2_MASK) == LEAD2_PAT)
            lead_need = 2'd1;
        else if ((in_byte_reg & LEAD3_MASK) == LEAD3_PAT)
            lead_need = 2'd2;
        else if ((in_byte_reg & LEAD4_MASK) == LEAD4_PAT)
            lead_need = 2'd3;
        lead_zero = (in_byte_reg == 8'h00);
        lead_hold = 1'b0;
        lead_emit = 1'b1;
        lead_byte = in_byte_reg;
        if (in_byte_reg >= ASCII_TOP)
        begin
            if ((lead_need == 2'd0) || in_last_reg)
                lead_byte = REPL_BYTE;
            else
            begin
                lead_emit = 1'b0;
                lead_hold = 1'b1;
            end
        end
    end

    // one step of the sanitizer
    always_comb
    begin
        is_cont   = ((in_byte_reg & CONT_MASK) == CONT_PAT);
        pre_n     = 2'd0;
        pre_repl  = 1'b0;
        tail_en   = 1'b0;
        tail_byte = in_byte_reg;
        hc_next   = hc_reg;
        nc_next   = nc_reg;
        pt_next   = pt_reg;
        hold_wr   = 1'b0;
        hold_idx  = 2'd0;
        if (pt_reg)
        begin
            tail_en = 1'b1;
        end
        else if ((hc_reg != 2'd0) && (nc_reg != 2'd0) && is_cont)
        begin
            if (nc_reg == 2'd1)
            begin
                // sequence complete: pass held bytes and this one
                pre_n   = hc_reg;
                tail_en = 1'b1;
                hc_next = 2'd0;
                nc_next = 2'd0;
            end
            else
            begin
                // extend the sequence
                if (hc_reg != 2'd3)
                begin
                    hold_wr  = 1'b1;
                    hold_idx = hc_reg;
                    hc_next  = hc_reg + 2'd1;
                end
                nc_next = nc_reg - 2'd1;
                if (in_last_reg)
                begin
                    pre_n    = hc_next;
                    pre_repl = 1'b1;
                end
            end
        end
        else
        begin
            // broken sequence (if any) flushes as replacements, then a new lead
            pre_n     = ((hc_reg != 2'd0) && (nc_reg != 2'd0)) ? hc_reg : 2'd0;
            pre_repl  = 1'b1;
            tail_en   = lead_emit;
            tail_byte = lead_byte;
            hc_next   = 2'd0;
            nc_next   = 2'd0;
            if (lead_zero)
                pt_next = 1'b1;
            if (lead_hold)
            begin
                hold_wr  = 1'b1;
                hold_idx = 2'd0;
                hc_next  = 2'd1;
                nc_next  = lead_need;
            end
        end
        if (in_last_reg)
        begin
            hc_next = 2'd0;
            nc_next = 2'd0;
            pt_next = 1'b0;
        end
        res_n = {1'b0, pre_n} + {2'b00, tail_en};
    end

    // result slot selection
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < pre_n)
                slot[k] = pre_repl ? REPL_BYTE : held_reg[k];
            else
                slot[k] = tail_byte;
        end
        slot[3] = tail_byte;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_xfer)
            in_vld_reg <= 1'b1;
        else if (move)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.in_last;
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 2'd0;
            nc_reg <= 2'd0;
            pt_reg <= 1'b0;
        end
        else if (move)
        begin
            hc_reg <= hc_next;
            nc_reg <= nc_next;
            pt_reg <= pt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move && hold_wr)
            held_reg[hold_idx] <= in_byte_reg;
    end

    // result buffer drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 3'd0;
            rd_reg     <= 2'd0;
        end
        else if (move)
        begin
            remain_reg <= res_n;
            rd_reg     <= 2'd0;
        end
        else if (out_xfer)
        begin
            remain_reg <= remain_reg - 3'd1;
            rd_reg     <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            for (int k = 0; k < MAX_OUT; k++)
                buf_reg[k] <= slot[k];
            buf_last_reg <= in_last_reg;
        end
    end

    // checks
    a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= 3'd4)
        else $error("result buffer count out of range");

    a_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (hc_reg == 2'd0) == (nc_reg == 2'd0))
        else $error("held and needed counts disagree");

    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, hc_reg} + {1'b0, nc_reg}) <= 3'd4)
        else $error("sequence longer than four bytes");

    a_pt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pt_reg |-> (hc_reg == 2'd0))
        else $error("sequence held during pass-through");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_last_reg) |=> (!pt_reg && (hc_reg == 2'd0)))
        else $error("state not cleared after final byte");

endmodule
